// ===== src/nal_length_prefix_to_start_code_top_macros.svh =====
// Assertion helpers for the start-code converter.
// Both macros sample on clk and are disabled while arst_n is low.
`ifndef NAL_LENGTH_PREFIX_TO_START_CODE_TOP_MACROS_SVH
`define NAL_LENGTH_PREFIX_TO_START_CODE_TOP_MACROS_SVH

// Same-cycle implication
`define NLSC_ASSERT_IMPLIES(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("nlsc: same-cycle check failed");

// Next-cycle implication
`define NLSC_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("nlsc: next-cycle check failed");

`endif

// ===== src/nlsc_pkg.sv =====
package nlsc_pkg;

	// One input beat
	typedef struct packed {
		logic [7:0] data_byte;
		logic       unit_end;
	} item_t;

	// One result beat
	typedef struct packed {
		logic [7:0] out_byte;
		logic [7:0] orig_byte;
		logic       end_of_unit;
		logic [1:0] unit_status;
	} result_t;

	// Framing of the current unit
	typedef enum logic [2:0] {
		MODE_UNDEC = 3'b001,
		MODE_PASS  = 3'b010,
		MODE_LEN   = 3'b100
	} mode_t;

	// Unit status codes
	localparam logic [1:0] ST_PASS      = 2'd0;
	localparam logic [1:0] ST_CLEAN     = 2'd1;
	localparam logic [1:0] ST_MALFORMED = 2'd2;

	// Start code bytes
	localparam logic [7:0] SC_ZERO = 8'h00;
	localparam logic [7:0] SC_LAST = 8'h01;

	// Prefix geometry
	localparam logic [1:0] PREFIX_LAST_PHASE = 2'd3;

endpackage

// ===== src/nal_length_prefix_to_start_code_top.sv =====
// Converts an access unit from 4-byte big-endian length prefixes to 00 00 00 01 start
// codes, one byte per beat, and passes a unit that already opens with a start code
// through unchanged. Each result beat also carries the raw input byte for fallback;
// unit_status on the final beat gives passthrough, clean conversion or malformed framing.
// Throughput is one byte per clock, except while result_stall is high or held opening
// bytes drain. Up to three opening bytes are held until the framing is known and then
// drain through the single result register, stalling the input while they go out.
// An accepted byte passes through the input register and then the result register.
`include "nal_length_prefix_to_start_code_top_macros.svh"

module nal_length_prefix_to_start_code_top (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               item_valid,
	output logic               item_stall,
	input  nlsc_pkg::item_t    item,
	output logic               result_valid,
	input  logic               result_stall,
	output nlsc_pkg::result_t  result
);

	logic               res_valid;
	logic               res_stall;
	nlsc_pkg::result_t  res;

	// Framing decision and byte conversion
	nlsc_conv u_conv (
		.clk        (clk),
		.arst_n     (arst_n),
		.item_valid (item_valid),
		.item_stall (item_stall),
		.item       (item),
		.res_valid  (res_valid),
		.res_stall  (res_stall),
		.res        (res)
	);

	// Result register
	nlsc_out_stage u_out (
		.clk          (clk),
		.arst_n       (arst_n),
		.res_valid    (res_valid),
		.res_stall    (res_stall),
		.res          (res),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.result       (result)
	);

	// Status shows only on the closing beat of a unit
	`NLSC_ASSERT_IMPLIES(a_status_on_end, result_valid && (result.unit_status != nlsc_pkg::ST_PASS), result.end_of_unit)
	// Only the three defined status codes appear
	`NLSC_ASSERT_IMPLIES(a_status_code, result_valid, (result.unit_status == nlsc_pkg::ST_PASS) || (result.unit_status == nlsc_pkg::ST_CLEAN) || (result.unit_status == nlsc_pkg::ST_MALFORMED))
	// Input stalls only while a result beat is pending or draining
	`NLSC_ASSERT_NEXT(a_stall_has_work, item_stall, result_valid)

endmodule

// ===== src/nlsc_conv.sv =====
module nlsc_conv (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               item_valid,
	output logic               item_stall,
	input  nlsc_pkg::item_t    item,
	output logic               res_valid,
	input  logic               res_stall,
	output nlsc_pkg::result_t  res
);

	// Input register
	logic             in_valid_s1;
	nlsc_pkg::item_t  in_s1;

	// Per-unit state
	logic [7:0]       held_q [3];
	logic [1:0]       hpos_q;
	nlsc_pkg::mode_t  mode_q;
	logic [1:0]       phase_q;
	logic [23:0]      accum_q;
	logic [31:0]      payload_q;
	logic             err_q;
	logic [1:0]       rel_q;

	logic [7:0]       b;
	logic             unit_end;
	logic [2:0]       cnt;
	logic [7:0]       hdr_c [4];
	logic             open001, open000, dec_pass, hold_c, last_c, retire;
	logic [2:0]       nres;

	// Header decision next state
	logic [1:0]       phase_d;
	logic [23:0]      accum_d;
	logic [31:0]      payload_d;
	logic             err_d;
	logic [7:0]       orig_r, out_r;

	// Merged next state and result bytes
	nlsc_pkg::mode_t  mode_n;
	logic [1:0]       phase_n;
	logic [23:0]      accum_n;
	logic [31:0]      payload_n;
	logic             err_n;
	logic [7:0]       out_b, orig_b;
	logic [31:0]      full_len;
	logic [1:0]       status_c;

	assign b        = in_s1.data_byte;
	assign unit_end = in_s1.unit_end;
	assign cnt      = {1'b0, hpos_q} + 3'd1;

	// Held bytes plus the current one, in unit order
	always_comb begin
		hdr_c[0] = (hpos_q == 2'd0) ? b : held_q[0];
		hdr_c[1] = (hpos_q == 2'd1) ? b : held_q[1];
		hdr_c[2] = (hpos_q == 2'd2) ? b : held_q[2];
		hdr_c[3] = b;
	end

	assign open000 = (hdr_c[0] == nlsc_pkg::SC_ZERO) && (hdr_c[1] == nlsc_pkg::SC_ZERO)
		&& (hdr_c[2] == nlsc_pkg::SC_ZERO);
	assign open001 = (hdr_c[0] == nlsc_pkg::SC_ZERO) && (hdr_c[1] == nlsc_pkg::SC_ZERO)
		&& (hdr_c[2] == nlsc_pkg::SC_LAST);

	assign dec_pass = ((cnt == 3'd3) && open001) || ((cnt == 3'd4) && (hdr_c[3] == nlsc_pkg::SC_LAST));
	assign hold_c   = (mode_q == nlsc_pkg::MODE_UNDEC) && !dec_pass && !unit_end
		&& (cnt != 3'd4) && ((cnt < 3'd3) || open000);

	// Results owed by the item in the input register
	assign nres   = (mode_q == nlsc_pkg::MODE_UNDEC) ? cnt : 3'd1;
	assign last_c = ({1'b0, rel_q} == (nres - 3'd1));

	// Length state after the held opening is read as prefix bytes
	always_comb begin
		phase_d   = (cnt == 3'd4) ? 2'd0 : cnt[1:0];
		payload_d = '0;
		err_d     = 1'b0;
		case (cnt)
			3'd1:    accum_d = {16'h0000, hdr_c[0]};
			3'd2:    accum_d = {8'h00, hdr_c[0], hdr_c[1]};
			3'd3:    accum_d = {hdr_c[0], hdr_c[1], hdr_c[2]};
			default: accum_d = '0;
		endcase
		if (cnt == 3'd4) begin
			if (hdr_c[3] == nlsc_pkg::SC_ZERO) err_d = 1'b1;
			else payload_d = {24'h000000, hdr_c[3]};
		end
	end

	// Released opening byte at the current burst index
	always_comb begin
		orig_r = hdr_c[rel_q];
		if (dec_pass) begin
			out_r = orig_r;
		end else if (rel_q == 2'd3) begin
			out_r = (hdr_c[3] == nlsc_pkg::SC_ZERO) ? orig_r : nlsc_pkg::SC_LAST;
		end else begin
			out_r = nlsc_pkg::SC_ZERO;
		end
	end

	assign full_len = {accum_q, b};

	// Result byte and next state per mode
	always_comb begin
		mode_n    = mode_q;
		phase_n   = phase_q;
		accum_n   = accum_q;
		payload_n = payload_q;
		err_n     = err_q;
		out_b     = b;
		orig_b    = b;
		unique case (mode_q)
			nlsc_pkg::MODE_UNDEC: begin
				orig_b = orig_r;
				out_b  = out_r;
				if (dec_pass) begin
					mode_n = nlsc_pkg::MODE_PASS;
				end else begin
					mode_n    = nlsc_pkg::MODE_LEN;
					phase_n   = phase_d;
					accum_n   = accum_d;
					payload_n = payload_d;
					err_n     = err_d;
				end
			end
			nlsc_pkg::MODE_PASS: begin
				out_b = b;
			end
			nlsc_pkg::MODE_LEN: begin
				if (err_q) begin
					out_b = b;
				end else if (payload_q != 32'd0) begin
					out_b     = b;
					payload_n = payload_q - 32'd1;
				end else if (phase_q != nlsc_pkg::PREFIX_LAST_PHASE) begin
					out_b   = nlsc_pkg::SC_ZERO;
					phase_n = phase_q + 2'd1;
					accum_n = {accum_q[15:0], b};
				end else begin
					phase_n = 2'd0;
					accum_n = '0;
					if (full_len == 32'd0) begin
						err_n = 1'b1;
						out_b = b;
					end else begin
						payload_n = full_len;
						out_b     = nlsc_pkg::SC_LAST;
					end
				end
			end
			default: begin
				out_b = b;
			end
		endcase
	end

	// Unit status as it stands after this byte
	always_comb begin
		if (mode_n == nlsc_pkg::MODE_PASS) status_c = nlsc_pkg::ST_PASS;
		else if (err_n || (phase_n != 2'd0) || (payload_n != 32'd0)) status_c = nlsc_pkg::ST_MALFORMED;
		else status_c = nlsc_pkg::ST_CLEAN;
	end

	// Result beat
	always_comb begin
		res.out_byte    = out_b;
		res.orig_byte   = orig_b;
		res.end_of_unit = unit_end && last_c;
		res.unit_status = (unit_end && last_c) ? status_c : nlsc_pkg::ST_PASS;
	end

	assign res_valid  = in_valid_s1 && !hold_c;
	assign retire     = in_valid_s1 && (hold_c || (last_c && !res_stall));
	assign item_stall = in_valid_s1 && !retire;

	// Control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid_s1 <= 1'b0;
			hpos_q      <= '0;
			mode_q      <= nlsc_pkg::MODE_UNDEC;
			phase_q     <= '0;
			accum_q     <= '0;
			payload_q   <= '0;
			err_q       <= 1'b0;
			rel_q       <= '0;
		end else begin
			if (item_valid && !item_stall) in_valid_s1 <= 1'b1;
			else if (retire) in_valid_s1 <= 1'b0;

			if (res_valid && !res_stall) rel_q <= last_c ? 2'd0 : rel_q + 2'd1;

			if (retire) begin
				if (unit_end) begin
					hpos_q    <= '0;
					mode_q    <= nlsc_pkg::MODE_UNDEC;
					phase_q   <= '0;
					accum_q   <= '0;
					payload_q <= '0;
					err_q     <= 1'b0;
				end else if (hold_c) begin
					hpos_q <= hpos_q + 2'd1;
				end else begin
					hpos_q    <= '0;
					mode_q    <= mode_n;
					phase_q   <= phase_n;
					accum_q   <= accum_n;
					payload_q <= payload_n;
					err_q     <= err_n;
				end
			end
		end
	end

	// Payload registers
	always_ff @(posedge clk) begin
		if (item_valid && !item_stall) in_s1 <= item;
		if (retire && hold_c) begin
			for (int k = 0; k < 3; k++) begin
				if (hpos_q == 2'(k)) held_q[k] <= b;
			end
		end
	end

endmodule

// ===== src/nlsc_out_stage.sv =====
module nlsc_out_stage (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               res_valid,
	output logic               res_stall,
	input  nlsc_pkg::result_t  res,
	output logic               result_valid,
	input  logic               result_stall,
	output nlsc_pkg::result_t  result
);

	logic               out_valid_q;
	nlsc_pkg::result_t  out_q;

	// Load when empty or when the held beat is taken
	assign res_stall = out_valid_q && result_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (!res_stall) begin
			out_valid_q <= res_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (res_valid && !res_stall) out_q <= res;
	end

	assign result_valid = out_valid_q;
	assign result       = out_q;

endmodule
